// ===== src/acm_pkg.sv =====
// shared types, mode codes and wrap helpers for the alarm clock mode controller
// no dependencies
package acm_pkg;

    localparam int TICK_W = 8;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int MODE_W = 4;

    localparam logic [MIN_W-1:0]  MINUTE_TOP = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_TOP   = 5'd23;
    localparam logic [TICK_W-1:0] PRESS_MAX  = 8'd255;

    localparam logic [TICK_W-1:0] TPS_RESET  = 8'd40;
    localparam logic [TICK_W-1:0] LONG_RESET = 8'd100;

    // configuration register indexes
    localparam logic CFG_TPS  = 1'b0;
    localparam logic CFG_LONG = 1'b1;

    // mode codes as seen on the output
    localparam logic [MODE_W-1:0] MODE_RUN    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SETMIN = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SETHR  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SETSEC = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ARM    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ALMIN  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ALHR   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DISARM = 4'd7;
    localparam logic [MODE_W-1:0] MODE_RING   = 4'd8;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_press_evt;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [MIN_W-1:0]  second;
        logic              armed;
        logic              buzzer;
    } t_result;

    function automatic logic [MIN_W-1:0] inc_min(input logic [MIN_W-1:0] v);
        inc_min = (v >= MINUTE_TOP) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [HOUR_W-1:0] inc_hour(input logic [HOUR_W-1:0] v);
        inc_hour = (v >= HOUR_TOP) ? '0 : v + 1'b1;
    endfunction

endpackage

// ===== src/acm_press.sv =====
// press classifier: turns the button level into short and long press events
// depends on acm_pkg
module acm_press (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_button,
    input  logic [acm_pkg::TICK_W-1:0] i_long_ticks,
    output acm_pkg::t_press_evt       o_evt
);

    logic                       r_active, n_active;
    logic                       r_prev;
    logic [acm_pkg::TICK_W-1:0] r_ticks, n_ticks;
    logic [acm_pkg::TICK_W-1:0] ticks_sat;

    assign ticks_sat = (r_ticks < acm_pkg::PRESS_MAX) ? r_ticks + 1'b1 : r_ticks;

    always_comb begin
        n_active          = r_active;
        n_ticks           = r_ticks;
        o_evt.short_press = 1'b0;
        o_evt.long_press  = 1'b0;
        if (r_active) begin
            if (!i_button) begin
                o_evt.short_press = 1'b1;
                n_active          = 1'b0;
            end else begin
                n_ticks = ticks_sat;
                if (ticks_sat >= i_long_ticks) begin
                    o_evt.long_press = 1'b1;
                    n_active         = 1'b0;
                end
            end
        end else if (i_button && !r_prev) begin
            n_active = 1'b1;
            n_ticks  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_prev   <= 1'b0;
            r_ticks  <= '0;
        end else if (i_en) begin
            r_active <= n_active;
            r_prev   <= i_button;
            r_ticks  <= n_ticks;
        end
    end

endmodule

// ===== src/acm_core.sv =====
// mode state machine, time of day, alarm time and alarm check
// depends on acm_pkg
module acm_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  acm_pkg::t_press_evt        i_evt,
    input  logic [acm_pkg::TICK_W-1:0] i_tps,
    output acm_pkg::t_result           o_res
);

    typedef enum logic [acm_pkg::MODE_W-1:0] {
        ST_RUN    = acm_pkg::MODE_RUN,
        ST_SETMIN = acm_pkg::MODE_SETMIN,
        ST_SETHR  = acm_pkg::MODE_SETHR,
        ST_SETSEC = acm_pkg::MODE_SETSEC,
        ST_ARM    = acm_pkg::MODE_ARM,
        ST_ALMIN  = acm_pkg::MODE_ALMIN,
        ST_ALHR   = acm_pkg::MODE_ALHR,
        ST_DISARM = acm_pkg::MODE_DISARM,
        ST_RING   = acm_pkg::MODE_RING
    } t_state;

    t_state                     r_state, n_state, st_p;
    logic [acm_pkg::TICK_W-1:0] r_tick, n_tick, tick_inc;
    logic [acm_pkg::HOUR_W-1:0] r_hour, n_hour, hour_p, r_whour, n_whour;
    logic [acm_pkg::MIN_W-1:0]  r_min, n_min, min_p, r_wmin, n_wmin;
    logic [acm_pkg::MIN_W-1:0]  r_sec, n_sec, sec_p;
    logic                       r_armed, n_armed, armed_p;
    logic                       r_rfd, n_rfd, rfd_p;
    logic                       press, lng, due, alarm_screen;

    assign press    = i_evt.short_press | i_evt.long_press;
    assign lng      = i_evt.long_press;
    assign tick_inc = r_tick + 1'b1;
    assign due      = (tick_inc >= i_tps);

    always_comb begin
        st_p    = r_state;
        hour_p  = r_hour;
        min_p   = r_min;
        sec_p   = r_sec;
        n_whour = r_whour;
        n_wmin  = r_wmin;
        armed_p = r_armed;
        rfd_p   = r_rfd;
        if (press) begin
            unique case (r_state)
                ST_SETMIN: begin
                    if (lng) st_p = ST_SETHR;
                    else     min_p = acm_pkg::inc_min(r_min);
                end
                ST_SETHR: begin
                    if (lng) st_p = ST_SETSEC;
                    else     hour_p = acm_pkg::inc_hour(r_hour);
                end
                ST_SETSEC: begin
                    if (lng) st_p = ST_RUN;
                    else     sec_p = '0;
                end
                ST_ARM: begin
                    st_p = lng ? ST_ALMIN : ST_RUN;
                end
                ST_ALMIN: begin
                    if (lng) st_p = ST_ALHR;
                    else     n_wmin = acm_pkg::inc_min(r_wmin);
                end
                ST_ALHR: begin
                    if (lng) begin
                        armed_p = 1'b1;
                        st_p    = ST_RUN;
                    end else begin
                        n_whour = acm_pkg::inc_hour(r_whour);
                    end
                end
                ST_DISARM: begin
                    if (lng) armed_p = 1'b0;
                    st_p = ST_RUN;
                end
                ST_RING: begin
                    armed_p = 1'b0;
                    st_p    = r_rfd ? ST_DISARM : ST_RUN;
                    rfd_p   = 1'b0;
                end
                default: begin
                    if (lng) st_p = ST_SETMIN;
                    else     st_p = r_armed ? ST_DISARM : ST_ARM;
                end
            endcase
        end

        // timekeeping after the press has acted
        n_state = st_p;
        n_hour  = hour_p;
        n_min   = min_p;
        n_sec   = sec_p;
        n_armed = armed_p;
        n_rfd   = rfd_p;
        n_tick  = due ? '0 : tick_inc;
        if (due) begin
            if (st_p == ST_SETMIN || st_p == ST_SETHR || st_p == ST_SETSEC) begin
                n_sec = acm_pkg::inc_min(sec_p);
            end else begin
                n_sec = acm_pkg::inc_min(sec_p);
                if (n_sec == '0) begin
                    n_min = acm_pkg::inc_min(min_p);
                    if (n_min == '0) n_hour = acm_pkg::inc_hour(hour_p);
                end
                if ((st_p == ST_RUN || st_p == ST_DISARM) && armed_p &&
                    n_hour == n_whour && n_min == n_wmin) begin
                    n_rfd   = (st_p == ST_DISARM);
                    n_state = ST_RING;
                end
            end
        end

        alarm_screen = (n_state == ST_ARM || n_state == ST_ALMIN ||
                        n_state == ST_ALHR || n_state == ST_DISARM) ||
                       (n_state == ST_RING && n_rfd);

        o_res.mode   = n_state;
        o_res.hour   = alarm_screen ? n_whour : n_hour;
        o_res.minute = alarm_screen ? n_wmin : n_min;
        o_res.second = n_sec;
        o_res.armed  = n_armed;
        o_res.buzzer = (n_state == ST_RING);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_tick  <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_whour <= '0;
            r_wmin  <= '0;
            r_armed <= 1'b0;
            r_rfd   <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_whour <= n_whour;
            r_wmin  <= n_wmin;
            r_armed <= n_armed;
            r_rfd   <= n_rfd;
        end
    end

endmodule

// ===== src/alarm_clock_mode_controller_unit.sv =====
// top level of the alarm clock mode controller: config registers and result register
// depends on acm_pkg, acm_press, acm_core
//
// One input beat is one timer tick carrying the button level; every accepted beat
// produces exactly one result beat. Press classification, the mode menu, the
// time-of-day counters and the alarm compare all settle in one pass of logic between
// the state registers and the result register, so a new tick can be taken in every
// cycle unless the output side stalls. The result register is the only buffering:
// it is refilled in the same cycle it is drained, and the input side stalls only
// while a result is held and the output side stalls. Configuration (ticks per
// second, long press threshold) is written through its own always-ready port and
// should be changed only while no tick is in flight. No clearing pass after reset.
module alarm_clock_mode_controller_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_button_pressed,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_mode,
    output logic [4:0] o_shown_hour,
    output logic [5:0] o_shown_minute,
    output logic [5:0] o_shown_second,
    output logic       o_alarm_armed,
    output logic       o_buzzer_on,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [acm_pkg::TICK_W-1:0] r_tps;
    logic [acm_pkg::TICK_W-1:0] r_long;
    logic                       r_out_valid;
    acm_pkg::t_result           r_out;
    acm_pkg::t_result           res;
    acm_pkg::t_press_evt        evt;
    logic                       accept;

    // input side frees up whenever the held result leaves this cycle
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps  <= acm_pkg::TPS_RESET;
            r_long <= acm_pkg::LONG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                acm_pkg::CFG_TPS:  r_tps  <= i_cfg_data;
                acm_pkg::CFG_LONG: r_long <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acm_press u_press (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_button     (i_button_pressed),
        .i_long_ticks (r_long),
        .o_evt        (evt)
    );

    acm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_evt   (evt),
        .i_tps   (r_tps),
        .o_res   (res)
    );

    // result register: valid flag is control, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mode         = r_out.mode;
    assign o_shown_hour   = r_out.hour;
    assign o_shown_minute = r_out.minute;
    assign o_shown_second = r_out.second;
    assign o_alarm_armed  = r_out.armed;
    assign o_buzzer_on    = r_out.buzzer;

endmodule

// ===== src/acm_checker.sv =====
// port-level checks for alarm_clock_mode_controller_unit, attached by bind
// depends on acm_pkg
module acm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_mode,
    input logic [5:0] o_shown_second,
    input logic       o_alarm_armed,
    input logic       o_buzzer_on
);

    // buzzer follows the ringing mode
    a_buzzer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_buzzer_on == (o_mode == acm_pkg::MODE_RING)))
        else $error("buzzer does not match ringing mode");

    // ringing only while armed
    a_ring_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_buzzer_on) |-> o_alarm_armed)
        else $error("ringing while disarmed");

    // input never stalls while the result register is empty
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result held");

    // an accepted tick shows up as a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted tick gave no result");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mode) && $stable(o_shown_second)))
        else $error("stalled result changed");

endmodule

bind alarm_clock_mode_controller_unit acm_checker u_acm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_mode         (o_mode),
    .o_shown_second (o_shown_second),
    .o_alarm_armed  (o_alarm_armed),
    .o_buzzer_on    (o_buzzer_on)
);
